FILE: rtl/core/sha1_pkg.sv
package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int CHAIN_WORDS = 5;
    localparam int QUEUE_DEPTH = 16;

    typedef logic [WORD_W-1:0] word_t;

    // one schedule word handed from the front to the back
    typedef struct packed {
        word_t word;
        logic  msg_end;
    } blk_word_t;

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // word position at which the 64-bit length starts
    localparam logic [3:0] LEN_POS = 4'd14;

    localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_INDEX = 3'(CHAIN_WORDS - 1);

    function automatic word_t h_init(input logic [2:0] idx);
        word_t val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    function automatic word_t rotl(input word_t x, input int unsigned n);
        word_t val;
        val = (x << n) | (x >> (WORD_W - n));
        return val;
    endfunction

endpackage

FILE: rtl/core/sha1_front.sv
module sha1_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        message_word,
    input  logic [2:0]         valid_bytes,
    input  logic               final_word,
    input  logic               message_valid,
    output logic               message_ready,
    output logic               push,
    output sha1_pkg::blk_word_t push_data,
    input  logic               full
);
    import sha1_pkg::*;

    typedef enum logic [4:0] {
        F_DATA   = 5'b00001,
        F_TAIL   = 5'b00010,
        F_ZERO   = 5'b00100,
        F_LEN_HI = 5'b01000,
        F_LEN_LO = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [23:0]  acc_reg, acc_next;
    logic [1:0]   acc_cnt_reg, acc_cnt_next;
    logic [63:0]  pad_reg, pad_next;
    logic         pad_two_reg, pad_two_next;
    logic [3:0]   wpos_reg, wpos_next;
    logic [60:0]  byte_cnt_reg, byte_cnt_next;

    logic [2:0]   nv;
    logic [31:0]  mask;
    logic [31:0]  masked;
    logic [55:0]  comb_bytes;
    logic [2:0]   n_bytes;
    logic [63:0]  tail;
    logic         accept;

    assign nv = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

    always_comb
    begin
        case (nv)
            3'd0:    mask = 32'h00000000;
            3'd1:    mask = 32'hFF000000;
            3'd2:    mask = 32'hFFFF0000;
            3'd3:    mask = 32'hFFFFFF00;
            default: mask = 32'hFFFFFFFF;
        endcase
    end

    // pending bytes first, then the new valid bytes, unused bytes zero
    assign masked     = message_word & mask;
    assign comb_bytes = {acc_reg, 32'd0} | ({masked, 24'd0} >> {acc_cnt_reg, 3'b000});
    assign n_bytes    = {1'b0, acc_cnt_reg} + nv;
    assign tail       = {comb_bytes, 8'd0} | ({PAD_BYTE, 56'd0} >> {n_bytes, 3'b000});

    assign message_ready = (state_reg == F_DATA) && !full;
    assign accept        = message_valid && message_ready;

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        acc_cnt_next  = acc_cnt_reg;
        pad_next      = pad_reg;
        pad_two_next  = pad_two_reg;
        byte_cnt_next = byte_cnt_reg;
        push          = 1'b0;
        push_data     = '{word: 32'd0, msg_end: 1'b0};
        case (state_reg)
            F_DATA:
            begin
                if (accept)
                begin
                    byte_cnt_next = byte_cnt_reg + 61'(nv);
                    if (final_word)
                    begin
                        pad_next     = tail;
                        pad_two_next = n_bytes[2];
                        acc_next     = 24'd0;
                        acc_cnt_next = 2'd0;
                        state_next   = F_TAIL;
                    end
                    else if (n_bytes[2])
                    begin
                        push           = 1'b1;
                        push_data.word = comb_bytes[55:24];
                        acc_next       = comb_bytes[23:0];
                        acc_cnt_next   = n_bytes[1:0];
                    end
                    else
                    begin
                        acc_next     = comb_bytes[55:32];
                        acc_cnt_next = n_bytes[1:0];
                    end
                end
            end
            F_TAIL:
            begin
                if (!full)
                begin
                    push           = 1'b1;
                    push_data.word = pad_reg[63:32];
                    if (pad_two_reg)
                    begin
                        pad_next     = {pad_reg[31:0], 32'd0};
                        pad_two_next = 1'b0;
                    end
                    else if (wpos_reg + 4'd1 == LEN_POS)
                    begin
                        state_next = F_LEN_HI;
                    end
                    else
                    begin
                        state_next = F_ZERO;
                    end
                end
            end
            F_ZERO:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    if (wpos_reg + 4'd1 == LEN_POS)
                    begin
                        state_next = F_LEN_HI;
                    end
                end
            end
            F_LEN_HI:
            begin
                if (!full)
                begin
                    push           = 1'b1;
                    push_data.word = byte_cnt_reg[60:29];
                    state_next     = F_LEN_LO;
                end
            end
            F_LEN_LO:
            begin
                if (!full)
                begin
                    push              = 1'b1;
                    push_data.word    = {byte_cnt_reg[28:0], 3'b000};
                    push_data.msg_end = 1'b1;
                    byte_cnt_next     = 61'd0;
                    state_next        = F_DATA;
                end
            end
            default:
            begin
                state_next = F_DATA;
            end
        endcase
    end

    assign wpos_next = push ? wpos_reg + 4'd1 : wpos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_DATA;
            acc_reg      <= 24'd0;
            acc_cnt_reg  <= 2'd0;
            pad_two_reg  <= 1'b0;
            wpos_reg     <= 4'd0;
            byte_cnt_reg <= 61'd0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            acc_cnt_reg  <= acc_cnt_next;
            pad_two_reg  <= pad_two_next;
            wpos_reg     <= wpos_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg <= pad_next;
    end

endmodule

FILE: rtl/core/sha1_queue.sv
module sha1_queue #(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sha1_pkg::blk_word_t push_data,
    output logic                full,
    input  logic                pop,
    output sha1_pkg::blk_word_t pop_data,
    output logic                empty
);
    import sha1_pkg::*;

    localparam int AW = $clog2(DEPTH);

    blk_word_t   mem_reg [DEPTH];
    blk_word_t   head_reg;
    logic [AW:0] wr_ptr_reg, wr_ptr_next;
    logic [AW:0] rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);

    assign pop_data    = head_reg;
    assign wr_ptr_next = (push && !full) ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (pop && !empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
        // head word after this edge, a write into that slot passes straight through
        if (push && !full && (wr_ptr_reg[AW-1:0] == rd_ptr_next[AW-1:0]))
        begin
            head_reg <= push_data;
        end
        else
        begin
            head_reg <= mem_reg[rd_ptr_next[AW-1:0]];
        end
    end

endmodule

FILE: rtl/core/sha1_back.sv
module sha1_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::blk_word_t pop_data,
    input  logic                empty,
    output logic                pop,
    output logic [31:0]         digest_word,
    output logic [2:0]          digest_index,
    output logic                digest_end,
    output logic                digest_valid,
    input  logic                digest_ready
);
    import sha1_pkg::*;

    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_ROUND = 4'b0010,
        B_FOLD  = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [3:0]  load_cnt_reg, load_cnt_next;
    logic [6:0]  round_reg, round_next;
    logic        msg_end_reg, msg_end_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    word_t       win_reg   [BLOCK_WORDS];
    word_t       win_next  [BLOCK_WORDS];
    word_t       work_reg  [CHAIN_WORDS];
    word_t       work_next [CHAIN_WORDS];
    word_t       chain_reg [CHAIN_WORDS];
    word_t       chain_next[CHAIN_WORDS];
    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_index_reg, out_index_next;
    logic        out_end_reg, out_end_next;

    word_t f_val;
    word_t k_val;
    word_t temp;
    word_t new_w;

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3]) |
                    (work_reg[2] & work_reg[3]);
            k_val = K_2;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K_3;
        end
    end

    // window slides one word per round, oldest word at the bottom
    assign temp  = rotl(work_reg[0], 5) + f_val + work_reg[4] + k_val + win_reg[0];
    assign new_w = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        round_next     = round_reg;
        msg_end_next   = msg_end_reg;
        out_idx_next   = out_idx_reg;
        win_next       = win_reg;
        work_next      = work_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_end_next   = out_end_reg;
        pop            = 1'b0;

        if (out_valid_reg && digest_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_LOAD:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[BLOCK_WORDS-1] = pop_data.word;
                    msg_end_next  = pop_data.msg_end;
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'(BLOCK_WORDS - 1))
                    begin
                        work_next  = chain_reg;
                        round_next = 7'd0;
                        state_next = B_ROUND;
                    end
                end
            end
            B_ROUND:
            begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = new_w;
                work_next[0] = temp;
                work_next[1] = work_reg[0];
                work_next[2] = rotl(work_reg[1], 30);
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                round_next   = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                begin
                    round_next = 7'd0;
                    state_next = B_FOLD;
                end
            end
            B_FOLD:
            begin
                for (int i = 0; i < CHAIN_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                state_next = msg_end_reg ? B_OUT : B_LOAD;
            end
            B_OUT:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[0];
                    out_index_next = out_idx_reg;
                    out_end_next   = (out_idx_reg == LAST_INDEX);
                    // shift out h0 first, refill with the initial values
                    for (int i = 0; i < CHAIN_WORDS - 1; i++)
                    begin
                        chain_next[i] = chain_reg[i+1];
                    end
                    chain_next[CHAIN_WORDS-1] = h_init(out_idx_reg);
                    if (out_idx_reg == LAST_INDEX)
                    begin
                        out_idx_next = 3'd0;
                        state_next   = B_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_LOAD;
            load_cnt_reg  <= 4'd0;
            round_reg     <= 7'd0;
            msg_end_reg   <= 1'b0;
            out_idx_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= h_init(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            round_reg     <= round_next;
            msg_end_reg   <= msg_end_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        work_reg      <= work_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_end_reg   <= out_end_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest_word  = out_word_reg;
    assign digest_index = out_index_reg;
    assign digest_end   = out_end_reg;

endmodule

FILE: rtl/core/sha1_message_hasher.sv
// sha-1 hasher over a stream of big-endian 32-bit message words
// input channel: message_word, valid_bytes (leading bytes that count, above 4
//   means 4) and final_word, one beat per word, handshake message_valid/ready
// short words pack byte by byte; final_word ends the message and starts padding
// output channel: five beats per message, digest_word with digest_index 0..4,
//   h0 first, digest_end on the fifth; handshake digest_valid/ready
// a front stage packs bytes and appends padding and the bit length, feeding
//   whole schedule words into a QUEUE_DEPTH-entry queue
// the back stage loads 16 words, runs one round a cycle and folds into the chain;
//   it pops no new word until the block is folded, so the single round unit sets the throughput
// after the last word the front pushes the padding and length words, stalling
//   while the queue is full; after the fold of the last block the B_OUT state
//   loads the first digest beat into the output register
// a stalled receiver holds the output register; the back stage then waits,
//   the queue fills and message_ready drops
// reset clears all control state and loads the initial chain values;
//   message_ready is high from the first cycle after reset is released
module sha1_message_hasher #(
    parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        final_word,
    input  logic        message_valid,
    output logic        message_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_end,
    output logic        digest_valid,
    input  logic        digest_ready
);
    import sha1_pkg::*;

    blk_word_t q_in;
    blk_word_t q_out;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    // byte packing and padding
    sha1_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .message_word  (message_word),
        .valid_bytes   (valid_bytes),
        .final_word    (final_word),
        .message_valid (message_valid),
        .message_ready (message_ready),
        .push          (q_push),
        .push_data     (q_in),
        .full          (q_full)
    );

    // decouples packing from compression
    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // compression rounds and digest output
    sha1_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_data     (q_out),
        .empty        (q_empty),
        .pop          (q_pop),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_end   (digest_end),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready)
    );

endmodule

FILE: rtl/core/sha1_checker.sv
module sha1_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        final_word,
    input logic        message_valid,
    input logic        message_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  digest_index,
    input logic        digest_end,
    input logic        digest_valid,
    input logic        digest_ready
);

    // stalled digest beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=>
            digest_valid && $stable(digest_word) && $stable(digest_index))
        else $error("digest beat changed while stalled");

    // end flag marks exactly the last digest word
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_end == (digest_index == 3'd4)))
        else $error("digest_end does not match digest_index");

    // a new message needs at least one block before the next digest
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest_end |=> !digest_valid)
        else $error("digest beat right after digest end");

    // padding blocks the input in the cycle after the final word
    assert property (@(posedge clk) disable iff (!rst_n)
        message_valid && message_ready && final_word |=> !message_ready)
        else $error("input ready right after final word");

    // digest words follow in order within one message
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest_end ##1 digest_valid |->
            digest_index == $past(digest_index) + 3'd1)
        else $error("digest index out of order");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (.*);

FILE: verif/tb_sha1_message_hasher.sv
module tb_sha1_message_hasher;

    import sha1_pkg::*;

    // one message beat as offered to the block
    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } msg_beat_t;

    // one digest beat as it should leave the block
    typedef struct {
        word_t       word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // sha-1 starting chain, h0 first
    localparam word_t CHAIN_START [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam int RAND_BEATS   = 410;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [31:0] message_word = '0;
    logic [2:0]  valid_bytes = '0;
    logic        final_word = 1'b0;
    logic        message_valid = 1'b0;
    logic        message_ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_end;
    logic        digest_valid;
    logic        digest_ready = 1'b0;

    // stimulus waiting for the driver, digests waiting for the block
    msg_beat_t    msg_pending[$];
    digest_beat_t digest_expected[$];

    // hashing state of the predictor
    word_t        chain_state [5];
    word_t        sched_window [16];
    logic [60:0]  byte_total;
    int unsigned  fill_pos;

    // progress counters
    int unsigned  beats_sent = 0;
    int unsigned  beats_seen = 0;
    int unsigned  messages_hashed = 0;
    int unsigned  blocks_compressed = 0;
    int unsigned  mismatches = 0;

    // receiver hold-off
    logic         rx_hold = 1'b0;
    logic         hold_done = 1'b0;
    int unsigned  hold_left = 0;

    sha1_message_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .message_word  (message_word),
        .valid_bytes   (valid_bytes),
        .final_word    (final_word),
        .message_valid (message_valid),
        .message_ready (message_ready),
        .digest_word   (digest_word),
        .digest_index  (digest_index),
        .digest_end    (digest_end),
        .digest_valid  (digest_valid),
        .digest_ready  (digest_ready)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void restart_chain();
        for (int i = 0; i < 5; i++)
        begin
            chain_state[i] = CHAIN_START[i];
        end
        byte_total = '0;
        fill_pos   = 0;
    endfunction

    // 80 rounds over the schedule window, folded into the chain
    function automatic void compress_window();
        word_t w [16];
        word_t a, b, c, d, e;
        word_t f, k, wj, t, x;
        w = sched_window;
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int j = 0; j < 80; j++)
        begin
            if (j < 16)
            begin
                wj = w[j];
            end
            else
            begin
                x  = w[(j + 13) % 16] ^ w[(j + 8) % 16] ^ w[(j + 2) % 16] ^ w[j % 16];
                wj = {x[30:0], x[31]};
                w[j % 16] = wj;
            end
            if (j < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_0;
            end
            else if (j < 40)
            begin
                f = b ^ c ^ d;
                k = K_1;
            end
            else if (j < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + wj;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_state[0] += a;
        chain_state[1] += b;
        chain_state[2] += c;
        chain_state[3] += d;
        chain_state[4] += e;
        blocks_compressed++;
    endfunction

    // place one byte big-endian into the window, compress on a full block
    function automatic void take_byte(input logic [7:0] b);
        int unsigned slot;
        int unsigned sh;
        slot = fill_pos / 4;
        sh   = (3 - (fill_pos % 4)) * 8;
        if (fill_pos % 4 == 0)
        begin
            sched_window[slot] = word_t'(b) << sh;
        end
        else
        begin
            sched_window[slot] |= word_t'(b) << sh;
        end
        fill_pos = (fill_pos + 1) % 64;
        if (fill_pos == 0)
        begin
            compress_window();
        end
    endfunction

    // one accepted message beat; on the last one pad and queue the digest
    function automatic void hash_beat(input logic [31:0] word, input logic [2:0] nbytes,
                                      input logic last);
        int unsigned  n;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        n = (nbytes > 3'd4) ? 4 : nbytes;
        for (int i = 0; i < n; i++)
        begin
            take_byte(word[31 - 8 * i -: 8]);
            byte_total = byte_total + 61'd1;
        end
        if (!last)
        begin
            return;
        end
        bit_len = {byte_total, 3'b000};
        take_byte(PAD_BYTE);
        while (fill_pos != 56)
        begin
            take_byte(8'h00);
        end
        for (int i = 0; i < 8; i++)
        begin
            take_byte(bit_len[63 - 8 * i -: 8]);
        end
        for (int i = 0; i < 5; i++)
        begin
            beat.word  = chain_state[i];
            beat.index = 3'(i);
            beat.last  = (i == 4);
            digest_expected.push_back(beat);
        end
        messages_hashed++;
        restart_chain();
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void add_beat(input logic [31:0] word, input logic [2:0] nbytes,
                                     input logic last);
        msg_beat_t beat;
        beat.word   = word;
        beat.nbytes = nbytes;
        beat.last   = last;
        msg_pending.push_back(beat);
    endfunction

    initial
    begin
        int unsigned kind;
        int unsigned len;
        logic [2:0]  nb;

        restart_chain();

        // directed: empty message, bits of the ignored word must not matter
        add_beat($urandom, 3'd0, 1'b1);
        // three valid bytes, trailing byte dropped
        add_beat(32'h616263A5, 3'd3, 1'b1);
        // counts above four act as four
        add_beat(32'hFFFFFFFF, 3'd7, 1'b0);
        add_beat(32'h00000000, 3'd5, 1'b0);
        add_beat($urandom, 3'd6, 1'b1);
        // short words mid-message pack byte by byte, an empty one too
        add_beat(32'h11AAAAAA, 3'd1, 1'b0);
        add_beat(32'h2233BBBB, 3'd2, 1'b0);
        add_beat(32'h445566CC, 3'd3, 1'b0);
        add_beat($urandom, 3'd0, 1'b0);
        add_beat(32'h778899AA, 3'd4, 1'b1);
        // 56 bytes: no room left for the length, padding spills into a second block
        for (int i = 0; i < 14; i++)
        begin
            add_beat((i == 0) ? 32'h0 : (i == 13) ? 32'hFFFFFFFF : $urandom, 3'd4, i == 13);
        end

        // random messages, mostly well formed, some noisy
        while (msg_pending.size() < RAND_BEATS)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
                    6, 7:             len = $urandom_range(13, 17);
                    8:                len = $urandom_range(18, 40);
                    default:          len = 1;
                endcase
                for (int i = 0; i < len; i++)
                begin
                    nb = 3'd4;
                    if (i == len - 1)
                    begin
                        nb = 3'($urandom_range(4));
                    end
                    else if ($urandom_range(19) == 0)
                    begin
                        nb = 3'($urandom_range(7));
                    end
                    add_beat($urandom, nb, i == len - 1);
                end
            end
            else
            begin
                // any count, stray last flags
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    add_beat($urandom, 3'($urandom_range(7)),
                             (i == len - 1) || ($urandom_range(7) == 0));
                end
            end
        end

        // reset once at the start
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // all beats offered and accepted
        while (msg_pending.size() != 0 || message_valid)
        begin
            @(posedge clk);
        end
        // all digests back
        while (digest_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // room for any stray digest beat
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d message beats, %0d messages, %0d blocks, %0d digest beats",
                 beats_sent, messages_hashed, blocks_compressed, beats_seen);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: next beat goes out once the current one is taken
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_valid <= 1'b0;
            message_word  <= '0;
            valid_bytes   <= '0;
            final_word    <= 1'b0;
        end
        else if (!message_valid || message_ready)
        begin
            // about one idle cycle in ten, none over a middle stretch of beats
            if (msg_pending.size() != 0 &&
                ((beats_sent >= 150 && beats_sent < 260) || $urandom_range(99) >= 10))
            begin
                message_word  <= msg_pending[0].word;
                valid_bytes   <= msg_pending[0].nbytes;
                final_word    <= msg_pending[0].last;
                message_valid <= 1'b1;
                void'(msg_pending.pop_front());
            end
            else
            begin
                message_valid <= 1'b0;
            end
        end
    end

    // accepted beat feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && message_valid && message_ready)
        begin
            hash_beat(message_word, valid_bytes, final_word);
            beats_sent <= beats_sent + 1;
        end
    end

    // ------------------------------------------------------------------
    // receiver
    // ------------------------------------------------------------------

    // one long hold-off early on, so the queue fills and message_ready drops
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold   <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (!hold_done && beats_seen >= 10)
        begin
            rx_hold   <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (rx_hold)
        begin
            if (hold_left == 0)
            begin
                rx_hold <= 1'b0;
            end
            else
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // ready stalls about one cycle in ten, never over a middle stretch of beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_ready <= 1'b0;
        end
        else
        begin
            digest_ready <= !rx_hold &&
                            ((beats_seen >= 60 && beats_seen < 160) || $urandom_range(99) >= 10);
        end
    end

    // monitor: each digest beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            beats_seen <= beats_seen + 1;
            if (digest_expected.size() == 0)
            begin
                $error("digest beat with nothing expected: word %h index %0d end %0d",
                       digest_word, digest_index, digest_end);
                mismatches++;
            end
            else
            begin
                if (digest_word !== digest_expected[0].word)
                begin
                    $error("digest_word expected %h got %h",
                           digest_expected[0].word, digest_word);
                    mismatches++;
                end
                if (digest_index !== digest_expected[0].index)
                begin
                    $error("digest_index expected %0d got %0d",
                           digest_expected[0].index, digest_index);
                    mismatches++;
                end
                if (digest_end !== digest_expected[0].last)
                begin
                    $error("digest_end expected %0d got %0d",
                           digest_expected[0].last, digest_end);
                    mismatches++;
                end
                void'(digest_expected.pop_front());
            end
        end
    end

endmodule

FILE: filelist.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_front.sv
rtl/core/sha1_queue.sv
rtl/core/sha1_back.sv
rtl/core/sha1_message_hasher.sv
rtl/core/sha1_checker.sv
verif/tb_sha1_message_hasher.sv
